### hw/rtl/water_ripple_height_field_defines.svh
// Assertion macros shared by the ripple height field RTL.
// Expects a clock named clock and an active-high synchronous reset named reset in scope.
`ifndef WATER_RIPPLE_HEIGHT_FIELD_DEFINES_SVH
`define WATER_RIPPLE_HEIGHT_FIELD_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define WRH_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Property that must hold in the cycle after its trigger.
`define WRH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/wrh_pkg.sv
// Shared types and constants for the ripple height field block.
// No dependencies; used by the channel interfaces, wrh_update and the top level.
`default_nettype none

package wrh_pkg;

   localparam int KIND_W   = 2;
   localparam int COORD_W  = 6;
   localparam int HEIGHT_W = 16;
   localparam int SHIFT_W  = 4;

   localparam logic [SHIFT_W-1:0] DAMP_SHIFT_RESET = SHIFT_W'(4);

   typedef enum logic [KIND_W-1:0] {
      REQ_WRITE   = 2'd0,
      REQ_READ    = 2'd1,
      REQ_STEP    = 2'd2,
      REQ_UNKNOWN = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_RD_ADDR,
      S_RD_DATA,
      S_STEP,
      S_DRAIN,
      S_STEP_DONE
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/wrh_req_if.sv
// Request channel of the ripple height field: valid/ready plus request payload.
// Depends on wrh_pkg for field widths.
`default_nettype none

interface wrh_req_if;
   logic                               valid;
   logic                               ready;
   logic [wrh_pkg::KIND_W-1:0]         req_type;
   logic [wrh_pkg::COORD_W-1:0]        cell_x;
   logic [wrh_pkg::COORD_W-1:0]        cell_z;
   logic signed [wrh_pkg::HEIGHT_W-1:0] write_height;

   modport source (output valid, req_type, cell_x, cell_z, write_height, input ready);
   modport sink   (input valid, req_type, cell_x, cell_z, write_height, output ready);
endinterface

`default_nettype wire

### hw/rtl/wrh_rsp_if.sv
// Response channel of the ripple height field: valid/ready plus response payload.
// Depends on wrh_pkg for field widths.
`default_nettype none

interface wrh_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [wrh_pkg::HEIGHT_W-1:0] read_height;
   logic [wrh_pkg::KIND_W-1:0]          done_kind;

   modport source (output valid, read_height, done_kind, input ready);
   modport sink   (input valid, read_height, done_kind, output ready);
endinterface

`default_nettype wire

### hw/rtl/water_ripple_height_field.sv
// Top level of the two-grid water ripple height field.
// Depends on wrh_pkg, wrh_req_if, wrh_rsp_if, wrh_update and the assertion macro header.
//
//   Channel  Direction  Handshake          Carries
//   req_     in         valid / ready      req_type, cell_x, cell_z, write_height
//   rsp_     out        valid / ready      read_height, done_kind
//   csr_     in         write enable only  damping_shift (4 bits)
//
// A write or unknown transaction loads its response when it is accepted; a read passes through
// the accept, address and data states. A step is accepted, sweeps the newest grid in raster
// order, drains the update pipeline and then answers. The sweep is paced by the single read
// port of the newest grid, which streams one cell a cycle.
// After reset a clearing pass zeroes both grids before requests are taken.
// The response register lets the next request be accepted in the cycle its predecessor leaves.
`default_nettype none
`include "water_ripple_height_field_defines.svh"

module water_ripple_height_field #(
   parameter int GRID_SIDE   = 64,
   parameter int HEIGHT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   wrh_req_if.sink                         req_chan,
   wrh_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [wrh_pkg::SHIFT_W-1:0]     csr_wr_data
);

   // Grids are stored with a power-of-two row stride so that a cell address is {row, column}.
   localparam int XW     = $clog2(GRID_SIDE);
   localparam int SIDE_P = 1 << XW;
   localparam int IW     = 2 * XW;
   // Coordinate compare width: holds both the port coordinate and GRID_SIDE itself.
   localparam int CW     = ((XW > wrh_pkg::COORD_W) ? XW : wrh_pkg::COORD_W) + 1;
   // Width that holds both a stored height and a port height for saturation.
   localparam int SW     = (HEIGHT_BITS > wrh_pkg::HEIGHT_W) ? HEIGHT_BITS : wrh_pkg::HEIGHT_W;

   localparam logic [IW-1:0] IDX_LAST   = {IW{1'b1}};
   localparam logic [IW-1:0] STEP_LAST  = IW'((GRID_SIDE - 1) * SIDE_P + GRID_SIDE - 2);
   localparam logic [IW-1:0] ROW_STRIDE = IW'(SIDE_P);
   localparam logic [XW-1:0] COL_LO     = XW'(1);
   localparam logic [XW-1:0] COL_HI     = XW'(GRID_SIDE - 2);
   localparam logic [XW-1:0] ROW_LO     = XW'(2);
   localparam logic [XW-1:0] ROW_HI     = XW'(GRID_SIDE - 1);
   localparam logic [CW-1:0] SIDE_C     = CW'(GRID_SIDE);

   localparam logic signed [SW-1:0] HGT_MAX =
      SW'((longint'(1) <<< (HEIGHT_BITS - 1)) - longint'(1));
   localparam logic signed [SW-1:0] HGT_MIN =
      SW'(-(longint'(1) <<< (HEIGHT_BITS - 1)));
   localparam logic signed [SW-1:0] OUT_MAX = SW'(32767);
   localparam logic signed [SW-1:0] OUT_MIN = SW'(-32768);

   // ------------------------------------------------------------------
   // Control state
   // ------------------------------------------------------------------
   wrh_pkg::state_type state_ff, state_in;
   logic [IW-1:0]      idx_ff;
   logic               newest_ff;
   logic [wrh_pkg::SHIFT_W-1:0] damping_ff;
   logic               p1_ff;
   logic [IW-1:0]      p1_idx_ff;

   logic [IW-1:0]      req_addr_ff;
   logic               req_inside_ff;

   logic                                rsp_valid_ff;
   logic signed [wrh_pkg::HEIGHT_W-1:0] rsp_height_ff;
   logic [wrh_pkg::KIND_W-1:0]          rsp_kind_ff;

   // Decoded outputs of the state machine.
   logic                                req_ready;
   logic                                rsp_load;
   logic signed [wrh_pkg::HEIGHT_W-1:0] rsp_height_in;
   logic [wrh_pkg::KIND_W-1:0]          rsp_kind_in;
   logic                                clr_we;
   logic                                step_run;
   logic                                newest_flip;

   logic               req_fire;
   logic               out_free;
   logic               pipe_empty;
   wrh_pkg::kind_type  req_kind;

   // ------------------------------------------------------------------
   // Grid memories and their ports
   // ------------------------------------------------------------------
   logic signed [HEIGHT_BITS-1:0] grid_a_mem [SIDE_P*SIDE_P];
   logic signed [HEIGHT_BITS-1:0] grid_b_mem [SIDE_P*SIDE_P];
   logic signed [HEIGHT_BITS-1:0] rd_a_ff;
   logic signed [HEIGHT_BITS-1:0] rd_b_ff;
   logic [IW-1:0]                 a_rd_addr, b_rd_addr;
   logic                          a_we, b_we;
   logic [IW-1:0]                 a_wr_addr, b_wr_addr;
   logic signed [HEIGHT_BITS-1:0] a_wr_data, b_wr_data;

   logic signed [HEIGHT_BITS-1:0] rd_newest;
   logic signed [HEIGHT_BITS-1:0] rd_older;

   // Tap line of the newest grid during a step: win_ff[k] holds the cell k+1 places back.
   logic signed [HEIGHT_BITS-1:0] win_ff [2*SIDE_P];

   // Request decode.
   logic [CW-1:0]                 x_ext, z_ext;
   logic                          req_inside;
   logic [IW-1:0]                 req_addr;
   logic signed [SW-1:0]          wr_ext;
   logic signed [HEIGHT_BITS-1:0] req_wr_data;
   logic signed [SW-1:0]          rd_ext;
   logic signed [wrh_pkg::HEIGHT_W-1:0] rd_sat;

   // Step datapath.
   logic [XW-1:0]                 p1_col, p1_row;
   logic                          p1_interior;
   logic                          upd_wr_valid;
   logic [IW-1:0]                 upd_wr_addr;
   logic [HEIGHT_BITS-1:0]        upd_wr_data;

   assign req_kind = wrh_pkg::kind_type'(req_chan.req_type);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire = req_chan.valid && req_ready;

   // Out-of-range coordinates are flagged before they are folded into an address.
   always_comb begin
      x_ext      = CW'(req_chan.cell_x);
      z_ext      = CW'(req_chan.cell_z);
      req_inside = (x_ext < SIDE_C) && (z_ext < SIDE_C);
      req_addr   = {z_ext[XW-1:0], x_ext[XW-1:0]};
   end

   // A written height saturates to the storage width.
   always_comb begin
      wr_ext = SW'(req_chan.write_height);
      priority if (wr_ext > HGT_MAX) begin
         req_wr_data = HGT_MAX[HEIGHT_BITS-1:0];
      end else if (wr_ext < HGT_MIN) begin
         req_wr_data = HGT_MIN[HEIGHT_BITS-1:0];
      end else begin
         req_wr_data = wr_ext[HEIGHT_BITS-1:0];
      end
   end

   assign rd_newest = newest_ff ? rd_b_ff : rd_a_ff;
   assign rd_older  = newest_ff ? rd_a_ff : rd_b_ff;

   // A read answer saturates to the 16-bit port when storage is wider.
   always_comb begin
      rd_ext = SW'(rd_newest);
      priority if (rd_ext > OUT_MAX) begin
         rd_sat = OUT_MAX[wrh_pkg::HEIGHT_W-1:0];
      end else if (rd_ext < OUT_MIN) begin
         rd_sat = OUT_MIN[wrh_pkg::HEIGHT_W-1:0];
      end else begin
         rd_sat = rd_ext[wrh_pkg::HEIGHT_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // State machine: next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wrh_pkg::S_CLEAR: begin
            if (idx_ff == IDX_LAST) state_in = wrh_pkg::S_IDLE;
         end
         wrh_pkg::S_IDLE: begin
            if (req_chan.valid && out_free) begin
               unique case (req_kind)
                  wrh_pkg::REQ_READ:    state_in = wrh_pkg::S_RD_ADDR;
                  wrh_pkg::REQ_STEP:    state_in = wrh_pkg::S_STEP;
                  wrh_pkg::REQ_WRITE,
                  wrh_pkg::REQ_UNKNOWN: state_in = wrh_pkg::S_IDLE;
               endcase
            end
         end
         wrh_pkg::S_RD_ADDR: begin
            state_in = wrh_pkg::S_RD_DATA;
         end
         wrh_pkg::S_RD_DATA: begin
            if (out_free) state_in = wrh_pkg::S_IDLE;
         end
         wrh_pkg::S_STEP: begin
            if (idx_ff == STEP_LAST) state_in = wrh_pkg::S_DRAIN;
         end
         wrh_pkg::S_DRAIN: begin
            if (pipe_empty) state_in = wrh_pkg::S_STEP_DONE;
         end
         wrh_pkg::S_STEP_DONE: begin
            if (out_free) state_in = wrh_pkg::S_IDLE;
         end
         default: state_in = wrh_pkg::S_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // State machine: outputs
   // ------------------------------------------------------------------
   always_comb begin
      req_ready     = 1'b0;
      rsp_load      = 1'b0;
      rsp_height_in = '0;
      rsp_kind_in   = req_chan.req_type;
      clr_we        = 1'b0;
      step_run      = 1'b0;
      newest_flip   = 1'b0;
      unique case (state_ff)
         wrh_pkg::S_CLEAR: begin
            clr_we = 1'b1;
         end
         wrh_pkg::S_IDLE: begin
            req_ready = out_free;
            // Writes and unknown requests answer at once with a zero height.
            if (req_chan.valid && out_free &&
                (req_kind == wrh_pkg::REQ_WRITE || req_kind == wrh_pkg::REQ_UNKNOWN)) begin
               rsp_load = 1'b1;
            end
         end
         wrh_pkg::S_RD_ADDR: begin
         end
         wrh_pkg::S_RD_DATA: begin
            rsp_kind_in = wrh_pkg::REQ_READ;
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_height_in = req_inside_ff ? rd_sat : '0;
            end
         end
         wrh_pkg::S_STEP: begin
            step_run = 1'b1;
         end
         wrh_pkg::S_DRAIN: begin
            // The grid roles swap once the last update has been written and the pipeline is empty.
            newest_flip = pipe_empty;
         end
         wrh_pkg::S_STEP_DONE: begin
            rsp_kind_in = wrh_pkg::REQ_STEP;
            rsp_load    = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= wrh_pkg::S_CLEAR;
         idx_ff     <= '0;
         newest_ff  <= 1'b0;
         damping_ff <= wrh_pkg::DAMP_SHIFT_RESET;
         p1_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         // The sweep counter walks the memory during the clearing pass and the step.
         if (clr_we || step_run) begin
            idx_ff <= idx_ff + IW'(1);
         end else if (state_ff == wrh_pkg::S_IDLE) begin
            idx_ff <= '0;
         end
         if (newest_flip) newest_ff <= !newest_ff;
         if (csr_wr_en) damping_ff <= csr_wr_data;
         p1_ff <= step_run;
      end
   end

   always_ff @(posedge clock) begin
      p1_idx_ff <= idx_ff;
      if (req_fire) begin
         req_addr_ff   <= req_addr;
         req_inside_ff <= req_inside;
      end
   end

   // ------------------------------------------------------------------
   // Response register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_height_ff <= rsp_height_in;
         rsp_kind_ff   <= rsp_kind_in;
      end
   end

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_height = rsp_height_ff;
   assign rsp_chan.done_kind   = rsp_kind_ff;

   // ------------------------------------------------------------------
   // Memory ports
   // ------------------------------------------------------------------
   // During a step the newest grid streams in raster order at the sweep index, and the
   // older grid is read one row behind, at the cell whose neighborhood is then complete.
   // Outside a step both read the latched request address, which holds for a read.
   always_comb begin
      if (step_run) begin
         a_rd_addr = newest_ff ? (idx_ff - ROW_STRIDE) : idx_ff;
         b_rd_addr = newest_ff ? idx_ff : (idx_ff - ROW_STRIDE);
      end else begin
         a_rd_addr = req_addr_ff;
         b_rd_addr = req_addr_ff;
      end
   end

   // Clearing, step write-back (older grid only) and request writes (newest grid only)
   // happen in different states, so the order below only settles the defaults.
   always_comb begin
      a_we      = 1'b0;
      a_wr_addr = req_addr;
      a_wr_data = req_wr_data;
      b_we      = 1'b0;
      b_wr_addr = req_addr;
      b_wr_data = req_wr_data;
      priority if (clr_we) begin
         a_we      = 1'b1;
         a_wr_addr = idx_ff;
         a_wr_data = '0;
         b_we      = 1'b1;
         b_wr_addr = idx_ff;
         b_wr_data = '0;
      end else if (upd_wr_valid) begin
         a_we      = newest_ff;
         a_wr_addr = upd_wr_addr;
         a_wr_data = upd_wr_data;
         b_we      = !newest_ff;
         b_wr_addr = upd_wr_addr;
         b_wr_data = upd_wr_data;
      end else if (req_fire && req_kind == wrh_pkg::REQ_WRITE && req_inside) begin
         a_we = !newest_ff;
         b_we = newest_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_we) grid_a_mem[a_wr_addr] <= a_wr_data;
      rd_a_ff <= grid_a_mem[a_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (b_we) grid_b_mem[b_wr_addr] <= b_wr_data;
      rd_b_ff <= grid_b_mem[b_rd_addr];
   end

   // ------------------------------------------------------------------
   // Step datapath
   // ------------------------------------------------------------------
   // The tap line shifts once per streamed cell, so two rows of history sit
   // behind the cell just read; that cell is the lower neighbor of the center one row back.
   always_ff @(posedge clock) begin
      if (p1_ff) begin
         win_ff[0] <= rd_newest;
         for (int k = 1; k < 2 * SIDE_P; k++) begin
            win_ff[k] <= win_ff[k-1];
         end
      end
   end

   // Only interior centers are updated; border cells of the older grid keep their value.
   always_comb begin
      p1_col      = p1_idx_ff[XW-1:0];
      p1_row      = p1_idx_ff[IW-1:XW];
      p1_interior = (p1_col >= COL_LO) && (p1_col <= COL_HI) &&
                    (p1_row >= ROW_LO) && (p1_row <= ROW_HI);
   end

   wrh_update #(
      .HEIGHT_BITS (HEIGHT_BITS),
      .ADDR_BITS   (IW)
   ) u_update (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (p1_ff && p1_interior),
      .in_addr    (p1_idx_ff - ROW_STRIDE),
      .nb_up      (win_ff[2*SIDE_P-1]),
      .nb_left    (win_ff[SIDE_P]),
      .nb_right   (win_ff[SIDE_P-2]),
      .nb_down    (rd_newest),
      .old_height (rd_older),
      .damp_shift (damping_ff),
      .wr_valid   (upd_wr_valid),
      .wr_addr    (upd_wr_addr),
      .wr_data    (upd_wr_data)
   );

   assign pipe_empty = !p1_ff && !upd_wr_valid;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `WRH_ASSERT_NOW(a_update_only_in_step, upd_wr_valid,
      (state_ff == wrh_pkg::S_STEP) || (state_ff == wrh_pkg::S_DRAIN),
      "step write-back outside a step")
   `WRH_ASSERT_NOW(a_newest_untouched_in_step,
      (state_ff == wrh_pkg::S_STEP) || (state_ff == wrh_pkg::S_DRAIN),
      newest_ff ? !b_we : !a_we, "newest grid written during a step")
   `WRH_ASSERT_NOW(a_rsp_no_overwrite, rsp_load, !rsp_valid_ff || rsp_chan.ready,
      "response register overwritten before it was taken")
   `WRH_ASSERT_NEXT(a_step_answer_after_swap, newest_flip,
      (state_ff == wrh_pkg::S_STEP_DONE) && (newest_ff != $past(newest_ff)),
      "step finished without swapping the grid roles")

endmodule

`default_nettype wire

### hw/rtl/wrh_update.sv
// Two-stage height update datapath for one interior cell of the ripple step.
// Depends on wrh_pkg for the shift width; instantiated by water_ripple_height_field.
`default_nettype none

module wrh_update #(
   parameter int HEIGHT_BITS = 16,
   parameter int ADDR_BITS   = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [ADDR_BITS-1:0]              in_addr,
   input  logic signed [HEIGHT_BITS-1:0]     nb_up,
   input  logic signed [HEIGHT_BITS-1:0]     nb_left,
   input  logic signed [HEIGHT_BITS-1:0]     nb_right,
   input  logic signed [HEIGHT_BITS-1:0]     nb_down,
   input  logic signed [HEIGHT_BITS-1:0]     old_height,
   input  logic [wrh_pkg::SHIFT_W-1:0]       damp_shift,
   output logic                              wr_valid,
   output logic [ADDR_BITS-1:0]              wr_addr,
   output logic [HEIGHT_BITS-1:0]            wr_data
);

   // Three guard bits cover the four-way sum and the damping subtraction.
   localparam int VW = HEIGHT_BITS + 3;
   localparam logic signed [VW-1:0] H_MAX =
      VW'((longint'(1) <<< (HEIGHT_BITS - 1)) - longint'(1));
   localparam logic signed [VW-1:0] H_MIN =
      VW'(-(longint'(1) <<< (HEIGHT_BITS - 1)));

   logic signed [VW-1:0] nb_sum;
   logic signed [VW-1:0] v_in;
   logic signed [VW-1:0] v_ff;
   logic signed [VW-1:0] damped;
   logic                 valid_ff;
   logic [ADDR_BITS-1:0] addr_ff;

   // Stage one: half the neighbor sum minus the older height.
   always_comb begin
      nb_sum = VW'(nb_up) + VW'(nb_left) + VW'(nb_right) + VW'(nb_down);
      v_in   = (nb_sum >>> 1) - VW'(old_height);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      addr_ff <= in_addr;
   end

   // Stage two: damping and saturation to the storage width.
   always_comb begin
      damped = v_ff - (v_ff >>> damp_shift);
      priority if (damped > H_MAX) begin
         wr_data = H_MAX[HEIGHT_BITS-1:0];
      end else if (damped < H_MIN) begin
         wr_data = H_MIN[HEIGHT_BITS-1:0];
      end else begin
         wr_data = damped[HEIGHT_BITS-1:0];
      end
   end

   assign wr_valid = valid_ff;
   assign wr_addr  = addr_ff;

endmodule

`default_nettype wire
